// ===== rtl/core/oest_pkg.sv =====
// Package for the oldest-evicting slot table.
// Holds the request and response word types, the entry and state types, and the opcodes.
// Depends on nothing.
package oest_pkg;

   localparam logic OP_ENTER = 1'b0;
   localparam logic OP_LEAVE = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [15:0] socket_id;
      logic [15:0] thread_id;
      logic [31:0] now;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  slot_index;
      logic        found;
      logic        evicted;
      logic [15:0] evicted_socket;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] socket;
      logic [15:0] owner;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

endpackage

// ===== rtl/core/oldest_evicting_slot_table_top.sv =====
// Top level of the oldest-evicting slot table.
// Holds the slot memory, the valid bits and the scan sequencer; uses oest_pkg.
//
// Usage: an enter word claims the lowest free slot, or evicts the slot with the
// smallest entry time when all are full and reports its socket for closing. A
// leave word frees the lowest valid slot whose owner matches the thread id.
// Both channels are valid/ready; every request word yields one response word.
// Slot data sits in a one-port memory read one address per cycle; the valid
// bits are flip-flops. One compare unit walks the slots in order, one slot per
// cycle, and stops at the first free slot (enter) or the first match (leave).
// A hit ends the scan early; otherwise it runs to the last slot. The next word
// is accepted the cycle after the response loads, and not before.
// The response sits in an output register; a stalled receiver holds it there,
// and a finished scan waits until that register is free.
// Reset clears all valid bits and the response valid; no clearing pass is
// needed, since the data of a slot is only used while the slot is valid.
module oldest_evicting_slot_table_top #(
   parameter int SLOT_COUNT = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  oest_pkg::req_word_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output oest_pkg::rsp_word_type rsp_data
);
   import oest_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   state_type              state_ff, state_in;
   req_word_type           req_ff;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic                   issue_ff, issue_in;
   logic                   rd_vld_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   entry_type              rd_data_ff;
   logic [SLOT_COUNT-1:0]  valid_ff;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [31:0]            best_time_ff, best_time_in;
   logic [15:0]            best_sock_ff, best_sock_in;
   logic [IDX_W-1:0]       target_ff, target_in;
   logic                   found_ff, found_in;
   logic                   evict_ff, evict_in;
   logic [15:0]            evsock_ff, evsock_in;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_data_ff;
   entry_type              mem [SLOT_COUNT];
   logic                   cur_valid;
   logic                   scan_done;
   logic                   rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cur_valid = valid_ff[rd_idx_ff];
   assign rsp_load  = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      best_idx_in  = best_idx_ff;
      best_time_in = best_time_ff;
      best_sock_in = best_sock_ff;
      target_in    = target_ff;
      found_in     = found_ff;
      evict_in     = evict_ff;
      evsock_in    = evsock_ff;
      scan_done    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               issue_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               if (cnt_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            if (rd_vld_ff) begin
               if (req_ff.opcode == OP_ENTER) begin
                  if (!cur_valid) begin
                     scan_done = 1'b1;
                     target_in = rd_idx_ff;
                     found_in  = 1'b1;
                     evict_in  = 1'b0;
                     evsock_in = '0;
                  end else begin
                     if (rd_idx_ff == '0 || rd_data_ff.stamp < best_time_ff) begin
                        best_idx_in  = rd_idx_ff;
                        best_time_in = rd_data_ff.stamp;
                        best_sock_in = rd_data_ff.socket;
                     end
                     if (rd_idx_ff == LAST_IDX) begin
                        scan_done = 1'b1;
                        target_in = best_idx_in;
                        found_in  = 1'b1;
                        evict_in  = 1'b1;
                        evsock_in = best_sock_in;
                     end
                  end
               end else begin
                  if (cur_valid && rd_data_ff.owner == req_ff.thread_id) begin
                     scan_done = 1'b1;
                     target_in = rd_idx_ff;
                     found_in  = 1'b1;
                  end else if (rd_idx_ff == LAST_IDX) begin
                     scan_done = 1'b1;
                     target_in = '0;
                     found_in  = 1'b0;
                  end
                  evict_in  = 1'b0;
                  evsock_in = '0;
               end
            end
            if (scan_done) begin
               state_in = ST_WRITE;
               issue_in = 1'b0;
            end
         end
         ST_WRITE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            issue_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= issue_ff && (state_ff == ST_SCAN) && !scan_done;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            if (req_ff.opcode == OP_ENTER) begin
               valid_ff[target_ff] <= 1'b1;
            end else if (found_ff) begin
               valid_ff[target_ff] <= 1'b0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      cnt_ff       <= cnt_in;
      rd_idx_ff    <= cnt_ff;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      best_sock_ff <= best_sock_in;
      target_ff    <= target_in;
      found_ff     <= found_in;
      evict_ff     <= evict_in;
      evsock_ff    <= evsock_in;
      if (rsp_load) begin
         rsp_data_ff.slot_index     <= 4'(target_ff);
         rsp_data_ff.found          <= found_ff;
         rsp_data_ff.evicted        <= evict_ff;
         rsp_data_ff.evicted_socket <= evsock_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && req_ff.opcode == OP_ENTER) begin
         mem[target_ff] <= '{socket: req_ff.socket_id,
                             owner:  req_ff.thread_id,
                             stamp:  req_ff.now};
      end else begin
         rd_data_ff <= mem[cnt_ff];
      end
   end

endmodule

// ===== rtl/core/oest_checker.sv =====
// Port checker for the oldest-evicting slot table, bound to the top level.
// Uses oest_pkg for the word types.
// Watches the request and response channels only.
module oest_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input oest_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input oest_pkg::rsp_word_type rsp_data
);
   import oest_pkg::*;

   // A stalled response word must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // The table is not ready again in the cycle after it takes a word.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted twice in a row");

   // A leave that found nothing reports slot zero and no eviction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.slot_index == '0 && !rsp_data.evicted && rsp_data.evicted_socket == '0)
      else $error("miss response carries data");

   // An eviction only happens on a successful enter.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> rsp_data.found)
      else $error("eviction without a found slot");

   // No response word right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind oldest_evicting_slot_table_top oest_checker u_oest_checker (.*);
